[src/isotp_frame_reassembler_top_macros.svh]
// Assertion macros for the ISO-TP frame reassembler.
`ifndef ISOTP_FRAME_REASSEMBLER_TOP_MACROS_SVH
`define ISOTP_FRAME_REASSEMBLER_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ISOTP_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("isotp reassembler: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define ISOTP_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("isotp reassembler: next-cycle check failed");

`endif

[src/isotp_pkg.sv]
// Shared types and constants of the ISO-TP frame reassembler.
package isotp_pkg;

  localparam int LENGTH_BITS = 12;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [3:0] FT_SINGLE = 4'h0;
  localparam logic [3:0] FT_FIRST  = 4'h1;
  localparam logic [3:0] FT_CONSEC = 4'h2;

  localparam logic [2:0] SF_MAX_LEN    = 3'd7;
  localparam logic [2:0] FF_DATA_BYTES = 3'd6;
  localparam logic [2:0] CF_DATA_BYTES = 3'd7;

  localparam logic [7:0] BLOCK_SIZE_RESET = 8'd10;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_FLOW = 2'd1,
    KIND_DONE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    TAIL_NONE = 2'd0,
    TAIL_FLOW = 2'd1,
    TAIL_DONE = 2'd2
  } tail_t;

  // One frame's worth of work for the back end.
  typedef struct packed {
    logic [7:0][7:0]         data;     // frame bytes 0..7
    logic                    ff_shift; // data starts at byte 2 rather than byte 1
    logic [2:0]              n_bytes;
    logic [LENGTH_BITS-1:0]  wpos;
    tail_t                   tail;
    logic [7:0]              fc_size;
    logic [LENGTH_BITS-1:0]  total;
  } job_t;

endpackage

[src/isotp_front.sv]
// Front end: accept frames, track protocol state, build one job per frame that causes a result word.
module isotp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_write_en,
  input  logic [7:0]        cfg_write_data,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [7:0]        in_frame_byte_0,
  input  logic [7:0]        in_frame_byte_1,
  input  logic [7:0]        in_frame_byte_2,
  input  logic [7:0]        in_frame_byte_3,
  input  logic [7:0]        in_frame_byte_4,
  input  logic [7:0]        in_frame_byte_5,
  input  logic [7:0]        in_frame_byte_6,
  input  logic [7:0]        in_frame_byte_7,
  output logic              job_push,
  output isotp_pkg::job_t   job
);
  import isotp_pkg::*;

  logic [7:0]             block_size_r;
  logic [3:0]             seq_r,    seq_nxt;
  logic [LENGTH_BITS-1:0] rem_r,    rem_nxt;
  logic [LENGTH_BITS-1:0] wpos_r,   wpos_nxt;
  logic [LENGTH_BITS-1:0] total_r,  total_nxt;
  logic [7:0]             fl_r,     fl_nxt;
  logic                   unl_r,    unl_nxt;
  logic                   in_msg_r, in_msg_nxt;

  logic                   accept;
  logic [3:0]             ftype;
  logic [3:0]             lnib;
  logic [LENGTH_BITS-1:0] ff_len;
  logic [7:0]             fl_dec;
  logic [LENGTH_BITS-1:0] rem_new;
  logic [2:0]             n;
  logic                   has_work;

  assign accept = in_valid && !in_stall;
  assign ftype  = in_frame_byte_0[7:4];
  assign lnib   = in_frame_byte_0[3:0];
  assign ff_len = {lnib, in_frame_byte_1};

  always_comb begin
    seq_nxt    = seq_r;
    rem_nxt    = rem_r;
    wpos_nxt   = wpos_r;
    total_nxt  = total_r;
    fl_nxt     = fl_r;
    unl_nxt    = unl_r;
    in_msg_nxt = in_msg_r;
    fl_dec     = fl_r;
    rem_new    = rem_r;
    n          = '0;
    has_work   = 1'b0;

    job.data     = {in_frame_byte_7, in_frame_byte_6, in_frame_byte_5, in_frame_byte_4,
                    in_frame_byte_3, in_frame_byte_2, in_frame_byte_1, in_frame_byte_0};
    job.ff_shift = 1'b0;
    job.n_bytes  = '0;
    job.wpos     = wpos_r;
    job.tail     = TAIL_NONE;
    job.fc_size  = block_size_r;
    job.total    = total_r;

    unique case (ftype)
      FT_SINGLE: begin
        n          = (lnib > {1'b0, SF_MAX_LEN}) ? SF_MAX_LEN : lnib[2:0];
        in_msg_nxt = 1'b0;
        total_nxt  = LENGTH_BITS'(n);
        wpos_nxt   = LENGTH_BITS'(n);
        rem_nxt    = '0;
        job.wpos   = '0;
        job.total  = LENGTH_BITS'(n);
        job.tail   = TAIL_DONE;
        has_work   = 1'b1;
      end
      FT_FIRST: begin
        n            = (ff_len < LENGTH_BITS'(FF_DATA_BYTES)) ? ff_len[2:0] : FF_DATA_BYTES;
        rem_new      = ff_len - LENGTH_BITS'(n);
        total_nxt    = ff_len;
        wpos_nxt     = LENGTH_BITS'(n);
        rem_nxt      = rem_new;
        job.ff_shift = 1'b1;
        job.wpos     = '0;
        job.total    = ff_len;
        has_work     = 1'b1;
        if (rem_new != '0) begin
          seq_nxt    = 4'd1;
          in_msg_nxt = 1'b1;
          fl_nxt     = block_size_r;
          unl_nxt    = (block_size_r == '0);
          job.tail   = TAIL_FLOW;
        end else begin
          in_msg_nxt = 1'b0;
          job.tail   = TAIL_DONE;
        end
      end
      FT_CONSEC: begin
        if (in_msg_r) begin
          // the frame counts against the block whether or not its number matches
          if (!unl_r && fl_r != '0) begin
            fl_dec = fl_r - 8'd1;
          end
          fl_nxt = fl_dec;
          if (lnib == seq_r) begin
            n        = (rem_r < LENGTH_BITS'(CF_DATA_BYTES)) ? rem_r[2:0] : CF_DATA_BYTES;
            rem_new  = rem_r - LENGTH_BITS'(n);
            wpos_nxt = wpos_r + LENGTH_BITS'(n);
            seq_nxt  = seq_r + 4'd1;
          end
          rem_nxt = rem_new;
          if (rem_new == '0) begin
            in_msg_nxt = 1'b0;
            job.tail   = TAIL_DONE;
          end else if (!unl_r && fl_dec == '0) begin
            fl_nxt   = block_size_r;
            unl_nxt  = (block_size_r == '0);
            job.tail = TAIL_FLOW;
          end
          has_work = (n != '0) || (job.tail != TAIL_NONE);
        end
      end
      default: begin
      end
    endcase
    job.n_bytes = n;
  end

  assign job_push = accept && has_work;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_size_r <= BLOCK_SIZE_RESET;
      seq_r        <= '0;
      rem_r        <= '0;
      wpos_r       <= '0;
      total_r      <= '0;
      fl_r         <= '0;
      unl_r        <= 1'b0;
      in_msg_r     <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        block_size_r <= cfg_write_data;
      end
      if (accept) begin
        seq_r    <= seq_nxt;
        rem_r    <= rem_nxt;
        wpos_r   <= wpos_nxt;
        total_r  <= total_nxt;
        fl_r     <= fl_nxt;
        unl_r    <= unl_nxt;
        in_msg_r <= in_msg_nxt;
      end
    end
  end

endmodule

[src/isotp_queue.sv]
// Short job queue between front and back end.
module isotp_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  isotp_pkg::job_t push_job,
  input  logic            pop,
  output logic            not_empty,
  output logic            full,
  output isotp_pkg::job_t head
);
  import isotp_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             ent_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r,    cnt_nxt;

  assign not_empty = (cnt_r != '0);
  assign full      = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign head      = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

[src/isotp_back.sv]
// Back end: jobs become result words in the output register, one per unstalled cycle.
module isotp_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               job_valid,
  input  isotp_pkg::job_t                    job,
  output logic                               job_pop,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         out_kind,
  output logic [7:0]                         out_payload,
  output logic [isotp_pkg::LENGTH_BITS-1:0]  out_byte_index,
  output logic [isotp_pkg::LENGTH_BITS-1:0]  out_message_length,
  output logic                               out_last
);
  import isotp_pkg::*;

  logic [2:0]             idx_r, idx_nxt;
  logic                   valid_r;
  kind_t                  kind_r;
  logic [7:0]             payload_r;
  logic [LENGTH_BITS-1:0] index_r;
  logic [LENGTH_BITS-1:0] len_r;
  logic                   last_r;

  logic                   adv;
  logic [3:0]             n_results;
  logic                   is_last;
  logic [2:0]             sel;
  kind_t                  kind_c;
  logic [7:0]             payload_c;
  logic [LENGTH_BITS-1:0] index_c;

  assign adv       = job_valid && (!valid_r || !out_stall);
  assign n_results = {1'b0, job.n_bytes} + ((job.tail != TAIL_NONE) ? 4'd1 : 4'd0);
  assign is_last   = ({1'b0, idx_r} + 4'd1) == n_results;
  assign sel       = idx_r + (job.ff_shift ? 3'd2 : 3'd1);
  assign job_pop   = adv && is_last;

  always_comb begin
    kind_c    = KIND_BYTE;
    payload_c = job.data[sel];
    index_c   = job.wpos + LENGTH_BITS'(idx_r);
    if (idx_r >= job.n_bytes) begin
      index_c = '0;
      if (job.tail == TAIL_FLOW) begin
        kind_c    = KIND_FLOW;
        payload_c = job.fc_size;
      end else begin
        kind_c    = KIND_DONE;
        payload_c = '0;
      end
    end
    idx_nxt = idx_r;
    if (adv) begin
      idx_nxt = is_last ? '0 : idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      if (adv) begin
        valid_r <= 1'b1;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind_r    <= kind_c;
      payload_r <= payload_c;
      index_r   <= index_c;
      len_r     <= job.total;
      last_r    <= is_last;
    end
  end

  assign out_valid          = valid_r;
  assign out_kind           = kind_r;
  assign out_payload        = payload_r;
  assign out_byte_index     = index_r;
  assign out_message_length = len_r;
  assign out_last           = last_r;

endmodule

[src/isotp_frame_reassembler_top.sv]
// ISO-TP receive reassembler top: front end, two-entry job queue, back end.
// A frame's first result word passes through the job queue and the back end's output register.
// Throughput: one result word per cycle while out_stall is low; a frame yields 1 to 8 words (its
// data bytes plus a flow-control or completion word where one is due); a frame that
// causes no word pushes no job. The input stalls only while the queue is full.
// Reset: synchronous active-low rst_n clears protocol state and queue, sets block size 10.
`include "isotp_frame_reassembler_top_macros.svh"

module isotp_frame_reassembler_top (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration: block size register
  input  logic                               cfg_write_en,
  input  logic [7:0]                         cfg_write_data,
  // frame input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         in_frame_byte_0,
  input  logic [7:0]                         in_frame_byte_1,
  input  logic [7:0]                         in_frame_byte_2,
  input  logic [7:0]                         in_frame_byte_3,
  input  logic [7:0]                         in_frame_byte_4,
  input  logic [7:0]                         in_frame_byte_5,
  input  logic [7:0]                         in_frame_byte_6,
  input  logic [7:0]                         in_frame_byte_7,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         out_kind,
  output logic [7:0]                         out_payload,
  output logic [isotp_pkg::LENGTH_BITS-1:0]  out_byte_index,
  output logic [isotp_pkg::LENGTH_BITS-1:0]  out_message_length,
  output logic                               out_last
);
  import isotp_pkg::*;

  logic q_push;
  logic q_pop;
  logic q_not_empty;
  logic q_full;
  job_t front_job;
  job_t head_job;

  // Hold off new frames only while the queue is full.
  assign in_stall = q_full;

  // Front end: decode the frame type, advance sequence, block and length state,
  // and push a job for any frame that causes at least one result word.
  isotp_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_write_en    (cfg_write_en),
    .cfg_write_data  (cfg_write_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_frame_byte_0 (in_frame_byte_0),
    .in_frame_byte_1 (in_frame_byte_1),
    .in_frame_byte_2 (in_frame_byte_2),
    .in_frame_byte_3 (in_frame_byte_3),
    .in_frame_byte_4 (in_frame_byte_4),
    .in_frame_byte_5 (in_frame_byte_5),
    .in_frame_byte_6 (in_frame_byte_6),
    .in_frame_byte_7 (in_frame_byte_7),
    .job_push        (q_push),
    .job             (front_job)
  );

  // Queue: decouple the frame side from the result side so each can stall alone.
  isotp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (front_job),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .full      (q_full),
    .head      (head_job)
  );

  // Back end: stream the data bytes, then the flow-control or completion word;
  // drop the job once its final word is loaded.
  isotp_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .job_valid          (q_not_empty),
    .job                (head_job),
    .job_pop            (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_payload        (out_payload),
    .out_byte_index     (out_byte_index),
    .out_message_length (out_message_length),
    .out_last           (out_last)
  );

  // The front end never pushes into a full queue.
  `ISOTP_ASSERT_IMP(a_no_overflow, q_push, !q_full)
  // Completion always closes a frame's words.
  `ISOTP_ASSERT_IMP(a_done_is_last, out_valid && out_kind == KIND_DONE, out_last)
  // Control words carry no byte position.
  `ISOTP_ASSERT_IMP(a_ctrl_index_zero, out_valid && out_kind != KIND_BYTE, out_byte_index == '0)
  // Words of one frame follow without a gap once taken.
  `ISOTP_ASSERT_NXT(a_frame_gapless, out_valid && !out_stall && !out_last, out_valid)

endmodule

[sim/tb_isotp_frame_reassembler_top.sv]
// Self-checking testbench for the ISO-TP frame reassembler: directed and random CAN frames.
module tb_isotp_frame_reassembler_top;
  import isotp_pkg::*;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 32;
  localparam int MAX_REPORTS   = 10;
  localparam int PRESSURE_HOLD = 300;
  localparam int PHASE_FRAMES  = 42;

  // Frame types the block ignores, used by the directed part.
  localparam logic [3:0] FT_FLOW_CTRL = 4'h3;
  localparam logic [3:0] FT_RESERVED  = 4'hF;

  // Byte i of a frame is frame[i]; byte 0 is the protocol control byte.
  typedef logic [7:0][7:0] frame_t;

  typedef struct {
    kind_t                  kind;
    logic [7:0]             payload;
    logic [LENGTH_BITS-1:0] index;
    logic [LENGTH_BITS-1:0] length;
    logic                   last;
  } result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_write_en = 1'b0;
  logic [7:0]             cfg_write_data = 8'd0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [7:0]             in_frame_byte_0 = 8'd0;
  logic [7:0]             in_frame_byte_1 = 8'd0;
  logic [7:0]             in_frame_byte_2 = 8'd0;
  logic [7:0]             in_frame_byte_3 = 8'd0;
  logic [7:0]             in_frame_byte_4 = 8'd0;
  logic [7:0]             in_frame_byte_5 = 8'd0;
  logic [7:0]             in_frame_byte_6 = 8'd0;
  logic [7:0]             in_frame_byte_7 = 8'd0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [1:0]             out_kind;
  logic [7:0]             out_payload;
  logic [LENGTH_BITS-1:0] out_byte_index;
  logic [LENGTH_BITS-1:0] out_message_length;
  logic                   out_last;

  isotp_frame_reassembler_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_write_en       (cfg_write_en),
    .cfg_write_data     (cfg_write_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_frame_byte_0    (in_frame_byte_0),
    .in_frame_byte_1    (in_frame_byte_1),
    .in_frame_byte_2    (in_frame_byte_2),
    .in_frame_byte_3    (in_frame_byte_3),
    .in_frame_byte_4    (in_frame_byte_4),
    .in_frame_byte_5    (in_frame_byte_5),
    .in_frame_byte_6    (in_frame_byte_6),
    .in_frame_byte_7    (in_frame_byte_7),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_payload        (out_payload),
    .out_byte_index     (out_byte_index),
    .out_message_length (out_message_length),
    .out_last           (out_last)
  );

  // Frames waiting to be offered, and result words the block still owes us.
  frame_t  frames_to_send[$];
  result_t results_due[$];
  frame_t  cur_frame = '0;

  // Shadow of the block's protocol state and its block size register,
  // starting from the reset values.
  logic [7:0]             block_size_now = BLOCK_SIZE_RESET;
  logic [3:0]             seq_due = 4'd0;
  logic [LENGTH_BITS-1:0] left_bytes = '0;
  logic [LENGTH_BITS-1:0] wr_pos = '0;
  logic [LENGTH_BITS-1:0] msg_total = '0;
  logic [7:0]             block_left = 8'd0;
  logic                   unlimited = 1'b0;
  logic                   active = 1'b0;

  // Knobs set per phase by the stimulus process.
  bit gaps_on = 1'b1;
  bit stall_on = 1'b1;
  bit pressure_arm = 1'b0;

  int gap_left = 0;
  int stall_left = 0;
  int frames_counted = 0;
  int mismatches = 0;
  int cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Idle length: mostly none, often short, now and then a long pause.
  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic frame_t rand_frame();
    return {$urandom, $urandom};
  endfunction

  // ---------------------------------------------------------------------
  // Reassembly predictor: works out the result words one frame causes.
  // ---------------------------------------------------------------------
  task automatic push_word(input kind_t kind, input logic [7:0] pay,
                           input logic [LENGTH_BITS-1:0] idx);
    result_t w;
    w.kind    = kind;
    w.payload = pay;
    w.index   = idx;
    w.length  = msg_total;
    w.last    = 1'b0;
    results_due.push_back(w);
  endtask

  // Stream n data bytes starting at frame byte 'first', advancing the write position.
  task automatic push_data(input frame_t f, input int first, input int n);
    for (int i = 0; i < n; i++) begin
      push_word(KIND_BYTE, f[(first + i) % 8], wr_pos);
      wr_pos = wr_pos + 1'b1;
    end
  endtask

  // Grant a fresh block: flow control with the current block size.
  task automatic grant_block();
    block_left = block_size_now;
    unlimited  = (block_size_now == 8'd0);
    push_word(KIND_FLOW, block_size_now, '0);
  endtask

  task automatic reassemble_frame(input frame_t f);
    logic [3:0]             nib;
    logic [LENGTH_BITS-1:0] n;
    int                     words_before;
    result_t                tail;
    nib = f[0][3:0];
    words_before = results_due.size();
    case (f[0][7:4])
      FT_SINGLE: begin
        // Clamp the length nibble; any open message is abandoned.
        n = (nib > SF_MAX_LEN) ? LENGTH_BITS'(SF_MAX_LEN) : LENGTH_BITS'(nib);
        active    = 1'b0;
        msg_total = n;
        wr_pos    = '0;
        push_data(f, 1, n);
        left_bytes = '0;
        push_word(KIND_DONE, 8'd0, '0);
      end
      FT_FIRST: begin
        msg_total = {nib, f[1]};
        wr_pos    = '0;
        n = (msg_total < FF_DATA_BYTES) ? msg_total : LENGTH_BITS'(FF_DATA_BYTES);
        push_data(f, 2, n);
        left_bytes = msg_total - n;
        if (left_bytes != 0) begin
          seq_due = 4'd1;
          active  = 1'b1;
          grant_block();
        end else begin
          active = 1'b0;
          push_word(KIND_DONE, 8'd0, '0);
        end
      end
      FT_CONSEC: begin
        // Outside a message a consecutive frame is simply dropped.
        if (active) begin
          // Every consecutive frame uses up the block, matched or not.
          if (!unlimited && block_left != 0) block_left = block_left - 1'b1;
          if (nib == seq_due) begin
            n = (left_bytes < CF_DATA_BYTES) ? left_bytes : LENGTH_BITS'(CF_DATA_BYTES);
            push_data(f, 1, n);
            left_bytes = left_bytes - n;
            seq_due    = seq_due + 1'b1;
          end
          if (left_bytes == 0) begin
            active = 1'b0;
            push_word(KIND_DONE, 8'd0, '0);
          end else if (!unlimited && block_left == 0) begin
            grant_block();
          end
        end
      end
      default: begin
        // Flow control and reserved types cause nothing.
      end
    endcase
    // Flag the frame's final word.
    if (results_due.size() > words_before) begin
      tail = results_due.pop_back();
      tail.last = 1'b1;
      results_due.push_back(tail);
    end
  endtask

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  // Queue a frame; ignored types do not count towards the phase's quota.
  task automatic add_frame(input frame_t f);
    frames_to_send.push_back(f);
    if (f[0][7:4] < FT_FLOW_CTRL) frames_counted++;
  endtask

  // One segmented message: a first frame and its consecutive frames, now and
  // then with a wrong sequence number or cut short so the next frame aborts it.
  task automatic add_message(input logic [LENGTH_BITS-1:0] len);
    frame_t     f;
    int         left;
    int         r;
    logic [3:0] seq;
    logic [3:0] skew;
    f = rand_frame();
    f[0] = {FT_FIRST, len[11:8]};
    f[1] = len[7:0];
    add_frame(f);
    left = int'(len) - 6;
    seq = 4'd1;
    while (left > 0) begin
      r = $urandom_range(0, 99);
      if (r < 3) break;
      f = rand_frame();
      if (r < 9) begin
        skew = 4'($urandom_range(1, 15));
        f[0] = {FT_CONSEC, seq + skew};
      end else begin
        f[0] = {FT_CONSEC, seq};
        seq  = seq + 1'b1;
        left = left - 7;
      end
      add_frame(f);
    end
  endtask

  // Mostly well-formed messages of random content, some single frames, some noise.
  task automatic random_phase(input int target);
    int     r;
    frame_t f;
    frames_counted = 0;
    while (frames_counted < target) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        r = $urandom_range(0, 99);
        if (r < 70)      add_message(LENGTH_BITS'($urandom_range(7, 40)));
        else if (r < 96) add_message(LENGTH_BITS'($urandom_range(41, 130)));
        else             add_message(LENGTH_BITS'($urandom_range(131, 300)));
      end else if (r < 82) begin
        f = rand_frame();
        f[0][7:4] = FT_SINGLE;
        add_frame(f);
      end else begin
        add_frame(rand_frame());
      end
    end
  endtask

  // Hold until every frame is taken and every word has come, then let the
  // block drain anything that causes no word.
  task automatic settle();
    while (frames_to_send.size() != 0 || in_valid || results_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_block_size(input logic [7:0] value);
    @(posedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value;
    block_size_now = value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Stimulus: reset, directed frames at the reset block size, then random
  // phases across block sizes including both extremes and "unlimited".
  // ---------------------------------------------------------------------
  initial begin
    frame_t     f;
    logic [7:0] bs;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single frames: empty, full of ones, over-long nibble, all zeros.
    f = '0;                                add_frame(f);
    f = '1; f[0] = {FT_SINGLE, 4'h7};      add_frame(f);
    f = rand_frame(); f[0] = {FT_SINGLE, 4'hF}; add_frame(f);
    f = '0; f[0] = {FT_SINGLE, 4'h3};      add_frame(f);
    // Ignored: stray consecutive frame, flow control, reserved type.
    f = rand_frame(); f[0] = {FT_CONSEC, 4'h1};    add_frame(f);
    f = rand_frame(); f[0] = {FT_FLOW_CTRL, 4'h0}; add_frame(f);
    f = '1; f[0] = {FT_RESERVED, 4'hF};            add_frame(f);
    // First frames that complete on their own: 5, 0 and 6 bytes.
    f = rand_frame(); f[0] = {FT_FIRST, 4'h0}; f[1] = 8'd5; add_frame(f);
    f = rand_frame(); f[0] = {FT_FIRST, 4'h0}; f[1] = 8'd0; add_frame(f);
    f = rand_frame(); f[0] = {FT_FIRST, 4'h0}; f[1] = 8'd6; add_frame(f);
    // 20-byte message with a sequence slip, then a stray frame after completion.
    f = rand_frame(); f[0] = {FT_FIRST, 4'h0}; f[1] = 8'd20; add_frame(f);
    f = rand_frame(); f[0] = {FT_CONSEC, 4'h1}; add_frame(f);
    f = rand_frame(); f[0] = {FT_CONSEC, 4'h3}; add_frame(f);
    f = rand_frame(); f[0] = {FT_CONSEC, 4'h2}; add_frame(f);
    f = rand_frame(); f[0] = {FT_CONSEC, 4'h3}; add_frame(f);
    // Longest announced length, slipped, then aborted by a single frame.
    f = '1; f[0] = {FT_FIRST, 4'hF};            add_frame(f);
    f = rand_frame(); f[0] = {FT_CONSEC, 4'h1}; add_frame(f);
    f = rand_frame(); f[0] = {FT_CONSEC, 4'hF}; add_frame(f);
    f = rand_frame(); f[0] = {FT_SINGLE, 4'h2}; add_frame(f);
    f = rand_frame(); f[0] = {FT_CONSEC, 4'h2}; add_frame(f);
    // Seven bytes: the last one alone in a consecutive frame.
    f = rand_frame(); f[0] = {FT_FIRST, 4'h0}; f[1] = 8'd7; add_frame(f);
    f = rand_frame(); f[0] = {FT_CONSEC, 4'h1}; add_frame(f);

    for (int p = 0; p < 6; p++) begin
      settle();
      gaps_on  = 1'b1;
      stall_on = 1'b1;
      case (p)
        0: bs = 8'd1;
        1: begin
          // Largest block; sender runs flat out while the receiver holds off.
          bs = 8'd255;
          gaps_on = 1'b0;
          pressure_arm = 1'b1;
        end
        2: begin
          // Unlimited block, no idling on either side.
          bs = 8'd0;
          gaps_on  = 1'b0;
          stall_on = 1'b0;
        end
        3: bs = 8'd2;
        4: bs = 8'($urandom_range(3, 254));
        default: bs = BLOCK_SIZE_RESET;
      endcase
      write_block_size(bs);
      random_phase(PHASE_FRAMES);
    end

    settle();
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // Frame driver: offer the next queued frame, hold it while stalled,
  // predict its words the moment it is taken.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        reassemble_frame(cur_frame);
        if (gaps_on) gap_left = pause_len();
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (frames_to_send.size() > 0) begin
        cur_frame = frames_to_send.pop_front();
        in_frame_byte_0 <= cur_frame[0];
        in_frame_byte_1 <= cur_frame[1];
        in_frame_byte_2 <= cur_frame[2];
        in_frame_byte_3 <= cur_frame[3];
        in_frame_byte_4 <= cur_frame[4];
        in_frame_byte_5 <= cur_frame[5];
        in_frame_byte_6 <= cur_frame[6];
        in_frame_byte_7 <= cur_frame[7];
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result stall: random pauses, plus one long hold-off once armed and the
  // sender is offering, so the job queue fills and the block stalls its input.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (pressure_arm && in_valid && stall_left == 0) begin
      pressure_arm = 1'b0;
      stall_left = PRESSURE_HOLD - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (stall_on) stall_left = pause_len();
    end
  end

  // ---------------------------------------------------------------------
  // Result monitor: compare every taken word with the oldest expectation.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected word: kind %0d payload %02h index %0d length %0d last %0b",
                   out_kind, out_payload, out_byte_index, out_message_length, out_last);
      end else begin
        want = results_due.pop_front();
        if (out_kind !== want.kind || out_payload !== want.payload ||
            out_byte_index !== want.index || out_message_length !== want.length ||
            out_last !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("word mismatch: want kind %0d payload %02h index %0d length %0d last %0b",
                     want.kind, want.payload, want.index, want.length, want.last);
            $display("               got  kind %0d payload %02h index %0d length %0d last %0b",
                     out_kind, out_payload, out_byte_index, out_message_length, out_last);
          end
        end
      end
    end
  end

  // Watchdog: drop the run if it overstays the cycle budget.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles, results_due.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule
